@@ hdl/afm_pkg.sv @@
`timescale 1ns / 1ps

package afm_pkg;

   localparam int READING_BITS = 44;
   localparam logic [READING_BITS-1:0] READING_MAX = {READING_BITS{1'b1}};

   localparam int FACTOR_BITS = 8;
   localparam int PROD_BITS   = READING_BITS + FACTOR_BITS;

   localparam int PERCENT_BITS = 7;
   localparam logic [PERCENT_BITS-1:0] PERCENT_SCALE = 7'd100;

   localparam int NUMERATOR_BITS = 20;
   localparam logic [NUMERATOR_BITS-1:0] PERIOD_NUMERATOR = 20'd1000000;

   localparam int THRESHOLD_BITS = 16;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd1000;
   localparam logic [PERCENT_BITS-1:0]   TOLERANCE_RESET = 7'd10;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWITCH_THRESHOLD  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE_PERCENT = 1'b1;

endpackage

@@ hdl/autoranging_frequency_meter_unit.sv @@
`timescale 1ns / 1ps

// Autoranging reciprocal frequency meter. Each req item carries a gated frequency count and a
// period count with their ready flags; each produces exactly one rsp item holding the latest
// good reading (Hz, FRACTION_BITS fraction bits), the out-of-window flag, the period-mode flag
// and whether this item made a new reading. An item that makes no reading is answered in the
// cycle after it is taken. A frequency reading, and a period reading of a zero count, passes
// through ST_MUL_LO, ST_CMP_LO and ST_CMP_HI; any other period reading first runs the
// restoring divider in ST_DIVIDE, which retires one quotient bit per cycle. The tolerance
// window bounds are computed one after the other on a single 44 x 8 multiplier. The block
// takes no new item until the current one is done and the rsp register is free or being
// drained in the same cycle. Config writes have no read-back.
module autoranging_frequency_meter_unit
   import afm_pkg::*;
#(
   parameter int COUNT_BITS    = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // freq_count[31:0], period_count[63:32]
   input  logic [1:0]  req_tuser,   // freq_ready[0], period_ready[1]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // frequency_q8[43:0], zero fill[47:44]
   output logic [2:0]  rsp_tuser,   // frequency_error[0], period_mode[1], updated[2]

   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [THRESHOLD_BITS-1:0] csr_wdata
);

   localparam int NUM_BITS  = NUMERATOR_BITS + FRACTION_BITS;
   localparam int CNT_BITS  = $clog2(NUM_BITS);
   localparam int FREQ_BITS = COUNT_BITS + 4 + FRACTION_BITS;
   localparam int WIDE_BITS = (FREQ_BITS > READING_BITS) ? FREQ_BITS : READING_BITS + 1;
   localparam logic [NUM_BITS-1:0] NUMERATOR = NUM_BITS'(PERIOD_NUMERATOR) << FRACTION_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MUL_LO,
      ST_CMP_LO,
      ST_CMP_HI
   } state_type;

   state_type state_ff;

   logic [THRESHOLD_BITS-1:0] threshold_ff;
   logic [PERCENT_BITS-1:0]   tolerance_ff;

   logic                    waiting_ff;
   logic [READING_BITS-1:0] previous_ff;
   logic [READING_BITS-1:0] current_ff;
   logic                    bad_ff;

   logic [READING_BITS-1:0] value_ff;
   logic [PROD_BITS-1:0]    prod_ff;
   logic                    low_bad_ff;

   logic [COUNT_BITS-1:0] divisor_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [NUM_BITS-1:0]   quo_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   logic                    rsp_valid_ff;
   logic [READING_BITS-1:0] rsp_freq_ff;
   logic                    rsp_error_ff;
   logic                    rsp_mode_ff;
   logic                    rsp_updated_ff;

   logic                  out_free;
   logic                  accept;
   logic                  rsp_load;
   logic                  freq_ready;
   logic                  period_ready;
   logic [COUNT_BITS-1:0] freq_count;
   logic [COUNT_BITS-1:0] period_count;
   logic                  freq_event;
   logic                  freq_take;
   logic                  waiting_in;
   logic                  period_take;

   logic [WIDE_BITS-1:0]    freq_wide;
   logic [READING_BITS-1:0] freq_value;

   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  trial_ge;
   logic [COUNT_BITS-1:0] rem_in;
   logic [NUM_BITS-1:0]   quo_in;

   logic [FACTOR_BITS-1:0] low_factor;
   logic [FACTOR_BITS-1:0] high_factor;
   logic [FACTOR_BITS-1:0] factor;
   logic [PROD_BITS-1:0]   product;
   logic [PROD_BITS-1:0]   scaled;
   logic                   outside;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign freq_ready   = req_tuser[0];
   assign period_ready = req_tuser[1];
   assign freq_count   = req_tdata[COUNT_BITS-1:0];
   assign period_count = req_tdata[32 +: COUNT_BITS];

   // frequency event first; a low count hands over to period mode in the same item
   assign freq_event  = freq_ready && !waiting_ff;
   assign freq_take   = freq_event && (32'(freq_count) >= 32'(threshold_ff));
   assign waiting_in  = waiting_ff || (freq_event && !freq_take);
   assign period_take = period_ready && waiting_in;

   // rsp register loads on an item without a reading or at the end of a reading
   assign rsp_load = (accept && !freq_take && !period_take)
                     || ((state_ff == ST_CMP_HI) && out_free);

   // count * 10, then to fixed point, saturated
   always_comb begin
      freq_wide = ((WIDE_BITS'(freq_count) << 3) + (WIDE_BITS'(freq_count) << 1))
                  << FRACTION_BITS;
      if (freq_wide > WIDE_BITS'(READING_MAX)) begin
         freq_value = READING_MAX;
      end else begin
         freq_value = freq_wide[READING_BITS-1:0];
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, quo_ff[NUM_BITS-1]};
      diff     = trial - {1'b0, divisor_ff};
      trial_ge = (trial >= {1'b0, divisor_ff});
      rem_in   = trial_ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_in   = {quo_ff[NUM_BITS-2:0], trial_ge};
   end

   // tolerance window on one shared multiplier
   always_comb begin
      low_factor  = (tolerance_ff >= PERCENT_SCALE) ?
                    '0 : FACTOR_BITS'(PERCENT_SCALE - tolerance_ff);
      high_factor = FACTOR_BITS'(PERCENT_SCALE) + FACTOR_BITS'(tolerance_ff);
      factor      = (state_ff == ST_MUL_LO) ? low_factor : high_factor;
      product     = PROD_BITS'(previous_ff) * PROD_BITS'(factor);
      scaled      = (PROD_BITS'(value_ff) << 6) + (PROD_BITS'(value_ff) << 5)
                    + (PROD_BITS'(value_ff) << 2);
      outside     = low_bad_ff || (scaled > prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         threshold_ff   <= THRESHOLD_RESET;
         tolerance_ff   <= TOLERANCE_RESET;
         waiting_ff     <= 1'b0;
         previous_ff    <= '0;
         current_ff     <= '0;
         bad_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SWITCH_THRESHOLD:  threshold_ff <= csr_wdata;
               CSR_TOLERANCE_PERCENT: tolerance_ff <= csr_wdata[PERCENT_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  waiting_ff <= waiting_in && !period_take;
                  divisor_ff <= period_count;
                  rem_ff     <= '0;
                  quo_ff     <= NUMERATOR;
                  cnt_ff     <= '0;
                  if (freq_take) begin
                     value_ff <= freq_value;
                     state_ff <= ST_MUL_LO;
                  end else if (period_take) begin
                     value_ff <= '0;
                     if (period_count == '0) begin
                        state_ff <= ST_MUL_LO;
                     end else begin
                        state_ff <= ST_DIVIDE;
                     end
                  end else begin
                     rsp_freq_ff    <= current_ff;
                     rsp_error_ff   <= bad_ff;
                     rsp_mode_ff    <= waiting_in;
                     rsp_updated_ff <= 1'b0;
                  end
               end
            end
            ST_DIVIDE: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
                  value_ff <= READING_BITS'(quo_in);
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_MUL_LO: begin
               prod_ff  <= product;
               state_ff <= ST_CMP_LO;
            end
            ST_CMP_LO: begin
               low_bad_ff <= (scaled < prod_ff);
               prod_ff    <= product;
               state_ff   <= ST_CMP_HI;
            end
            ST_CMP_HI: begin
               if (out_free) begin
                  previous_ff <= value_ff;
                  bad_ff      <= outside;
                  if (!outside) begin
                     current_ff <= value_ff;
                  end
                  rsp_freq_ff    <= outside ? current_ff : value_ff;
                  rsp_error_ff   <= outside;
                  rsp_mode_ff    <= waiting_ff;
                  rsp_updated_ff <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_freq_ff};
   assign rsp_tuser  = {rsp_updated_ff, rsp_mode_ff, rsp_error_ff};

   // an item with no ready event is answered next cycle without a new reading
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0] && !req_tuser[1])
      |=> (rsp_tvalid && !rsp_tuser[2]))
      else $error("idle item not answered at once");

   // a reading always leaves the meter in frequency mode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> !rsp_tuser[2])
      else $error("reading reported while in period mode");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (cnt_ff <= CNT_BITS'(NUM_BITS - 1)))
      else $error("divider ran past its last step");

endmodule
